### hdl/tss_pkg.sv
`default_nettype none
// ============================================================================
// tss_pkg
// Types, character codes and substitution tables for the typographic
// substitution stream.
// ============================================================================
package tss_pkg;

    localparam int WIN_DEPTH = 8;
    localparam int NUM_PAT   = 20;

    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_AMP = 8'h26;

    typedef struct packed {
        logic       kind;
        logic [7:0] in_byte;
        logic       run_end;
    } tss_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } tss_out_t;

    typedef enum logic [1:0] {
        OP_TEXT  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_PARA  = 2'd2
    } tss_op_t;

    typedef struct packed {
        tss_op_t    op;
        logic [7:0] data;
    } tss_cmd_t;

    typedef struct packed {
        logic     valid;
        tss_cmd_t cmd;
    } tss_link_t;

    typedef logic [WIN_DEPTH-1:0][7:0] tss_win_t;

    typedef enum logic [3:0] {
        ENT_NONE,
        ENT_RSQUO,
        ENT_MDASH,
        ENT_NDASH,
        ENT_HELLIP,
        ENT_COPY,
        ENT_REG,
        ENT_TRADE,
        ENT_FRAC34,
        ENT_FRAC12,
        ENT_FRAC14
    } tss_ent_t;

    // body is right-aligned, first char in the highest used byte
    typedef struct packed {
        logic       lead;
        logic [2:0] n;
        logic [63:0] body;
        tss_ent_t   ent;
        logic [2:0] skip;
    } pat_t;

    // right-aligned text, len bytes
    typedef struct packed {
        logic [63:0] text;
        logic [3:0]  len;
    } tss_str_t;

    function automatic logic is_boundary(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13) ||
               (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic pat_t pat_entry(input logic [4:0] k);
        pat_t p;
        p = '{1'b0, 3'd0, 64'd0, ENT_NONE, 3'd0};
        case (k)
            5'd0:  p = '{1'b0, 3'd3, 64'("'s>"),     ENT_RSQUO,  3'd0};
            5'd1:  p = '{1'b0, 3'd3, 64'("'t>"),     ENT_RSQUO,  3'd0};
            5'd2:  p = '{1'b0, 3'd4, 64'("'re>"),    ENT_RSQUO,  3'd0};
            5'd3:  p = '{1'b0, 3'd4, 64'("'ll>"),    ENT_RSQUO,  3'd0};
            5'd4:  p = '{1'b0, 3'd4, 64'("'ve>"),    ENT_RSQUO,  3'd0};
            5'd5:  p = '{1'b0, 3'd3, 64'("'m>"),     ENT_RSQUO,  3'd0};
            5'd6:  p = '{1'b0, 3'd3, 64'("'d>"),     ENT_RSQUO,  3'd0};
            5'd7:  p = '{1'b0, 3'd2, 64'("--"),      ENT_MDASH,  3'd1};
            5'd8:  p = '{1'b1, 3'd2, 64'("->"),      ENT_NDASH,  3'd0};
            5'd9:  p = '{1'b0, 3'd3, 64'("..."),     ENT_HELLIP, 3'd2};
            5'd10: p = '{1'b0, 3'd5, 64'(". . ."),   ENT_HELLIP, 3'd4};
            5'd11: p = '{1'b0, 3'd3, 64'("(c)"),     ENT_COPY,   3'd2};
            5'd12: p = '{1'b0, 3'd3, 64'("(r)"),     ENT_REG,    3'd2};
            5'd13: p = '{1'b0, 3'd4, 64'("(tm)"),    ENT_TRADE,  3'd3};
            5'd14: p = '{1'b1, 3'd4, 64'("3/4>"),    ENT_FRAC34, 3'd2};
            5'd15: p = '{1'b1, 3'd7, 64'("3/4ths>"), ENT_FRAC34, 3'd2};
            5'd16: p = '{1'b1, 3'd4, 64'("1/2>"),    ENT_FRAC12, 3'd2};
            5'd17: p = '{1'b1, 3'd4, 64'("1/4>"),    ENT_FRAC14, 3'd2};
            5'd18: p = '{1'b1, 3'd6, 64'("1/4th>"),  ENT_FRAC14, 3'd2};
            5'd19: p = '{1'b0, 3'd4, 64'("&#0;"),    ENT_NONE,   3'd3};
            default: p = '{1'b0, 3'd0, 64'd0, ENT_NONE, 3'd0};
        endcase
        return p;
    endfunction

    function automatic tss_str_t ent_text(input tss_ent_t e);
        tss_str_t s;
        s = '{64'd0, 4'd0};
        unique case (e)
            ENT_RSQUO:  s = '{64'("&rsquo;"),  4'd7};
            ENT_MDASH:  s = '{64'("&mdash;"),  4'd7};
            ENT_NDASH:  s = '{64'("&ndash;"),  4'd7};
            ENT_HELLIP: s = '{64'("&hellip;"), 4'd8};
            ENT_COPY:   s = '{64'("&copy;"),   4'd6};
            ENT_REG:    s = '{64'("&reg;"),    4'd5};
            ENT_TRADE:  s = '{64'("&trade;"),  4'd7};
            ENT_FRAC34: s = '{64'("&frac34;"), 4'd8};
            ENT_FRAC12: s = '{64'("&frac12;"), 4'd8};
            ENT_FRAC14: s = '{64'("&frac14;"), 4'd8};
            default:    s = '{64'd0, 4'd0};
        endcase
        return s;
    endfunction

    function automatic tss_str_t esc_text(input logic [7:0] c);
        tss_str_t s;
        s = '{{56'd0, c}, 4'd1};
        if (c == CH_LT)       s = '{64'("&lt;"),   4'd4};
        else if (c == CH_GT)  s = '{64'("&gt;"),   4'd4};
        else if (c == CH_AMP) s = '{64'("&amp;"),  4'd5};
        else if (c == CH_DQ)  s = '{64'("&quot;"), 4'd6};
        return s;
    endfunction

    function automatic tss_str_t quote_text(input logic open, input logic single);
        tss_str_t s;
        logic [7:0] rl;
        logic [7:0] sd;
        rl = open ? 8'h72 : 8'h6C;
        sd = single ? 8'h73 : 8'h64;
        s = '{{8'd0, CH_AMP, rl, sd, 32'("quo;")}, 4'd7};
        return s;
    endfunction

    // a set lead flag needs a boundary before the head; trailing '>' a boundary after
    function automatic logic pat_match(input pat_t p, input tss_win_t w,
                                       input logic [3:0] fill, input logic have_prev,
                                       input logic [7:0] prev);
        logic       res;
        logic       done;
        logic [7:0] ch;
        logic [7:0] c;
        res  = 1'b1;
        done = 1'b0;
        ch   = 8'd0;
        if (p.lead && (!have_prev || !is_boundary(prev)))
        begin
            res  = 1'b0;
            done = 1'b1;
        end
        for (int j = 0; j < WIN_DEPTH - 1; j++)
        begin
            c = to_lower(w[j]);
            if (!done && j < int'(p.n))
            begin
                ch = p.body[8*(int'(p.n)-1-j) +: 8];
                if (j >= int'(fill))
                begin
                    res  = (ch == CH_GT);
                    done = 1'b1;
                end
                else if (ch == CH_GT)
                begin
                    res  = is_boundary(c);
                    done = 1'b1;
                end
                else if (c != ch)
                begin
                    res  = 1'b0;
                    done = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### hdl/tss_front.sv
`default_nettype none
// ============================================================================
// tss_front
// Input stage: takes words, sorts them into text, run flush or paragraph end.
// ============================================================================
module tss_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tss_pkg::tss_in_t  in_word,
    output tss_pkg::tss_link_t     cmd,
    input  wire logic              q_full
);
    import tss_pkg::*;

    logic     cmd_valid_reg, cmd_valid_next;
    tss_cmd_t cmd_reg, cmd_next;
    logic     take;

    assign in_stall = cmd_valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg && q_full;
        cmd_next       = cmd_reg;
        if (take)
        begin
            cmd_valid_next = 1'b1;
            cmd_next.data  = in_word.in_byte;
            if (in_word.kind)
                cmd_next.op = OP_PARA;
            else if (in_word.run_end)
                cmd_next.op = OP_FLUSH;
            else
                cmd_next.op = OP_TEXT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else
            cmd_valid_reg <= cmd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd.valid = cmd_valid_reg;
    assign cmd.cmd   = cmd_reg;

endmodule
`default_nettype wire

### hdl/tss_queue.sv
`default_nettype none
// ============================================================================
// tss_queue
// Short command queue between the front and back stages.
// ============================================================================
module tss_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tss_pkg::tss_link_t  push,
    output logic                     full,
    output tss_pkg::tss_link_t       head,
    input  wire logic                pop
);
    import tss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tss_cmd_t        mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push_en;

    assign full    = (count_reg == CW'(DEPTH));
    assign push_en = push.valid && !full;

    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push_en)
            mem[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_en)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push_en && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule
`default_nettype wire

### hdl/tss_back.sv
`default_nettype none
// ============================================================================
// tss_back
// Render engine: lookahead window, pattern match, entity emission.
// ============================================================================
module tss_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tss_pkg::tss_link_t  head,
    output logic                     pop,
    input  wire logic                smart_mode,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output tss_pkg::tss_out_t        out_word
);
    import tss_pkg::*;

    typedef enum logic [3:0] {
        S_FETCH  = 4'b0001,
        S_RENDER = 4'b0010,
        S_EMIT   = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    tss_win_t    win_reg, win_next;
    logic [3:0]  fill_reg, fill_next;
    logic [7:0]  prev_reg, prev_next;
    logic        have_prev_reg, have_prev_next;
    logic [2:0]  skip_reg, skip_next;
    logic        sq_open_reg, sq_open_next;
    logic        dq_open_reg, dq_open_next;
    logic        flush_reg, flush_next;
    logic [3:0]  rem_reg, rem_next;
    logic [63:0] buf_reg, buf_next;
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg, hold_byte_next;
    logic        out_valid_reg, out_valid_next;
    tss_out_t    out_word_reg, out_word_next;

    // render decision for the window head
    logic [NUM_PAT-1:0] hit_vec;
    logic [4:0]         hit_idx;
    pat_t               hit_pat;
    logic [7:0]         head_byte;
    logic               dq_ok, sq_ok;
    tss_str_t           dec_str;
    logic [2:0]         dec_skip;
    logic               dec_dq_flip, dec_sq_flip;

    logic               out_free;
    logic               push_out;
    tss_out_t           push_word;
    logic [2:0]         emit_idx;

    assign head_byte = win_reg[0];

    always_comb
    begin
        for (int k = 0; k < NUM_PAT; k++)
            hit_vec[k] = pat_match(pat_entry(5'(k)), win_reg, fill_reg, have_prev_reg, prev_reg);
        hit_idx = '0;
        for (int k = NUM_PAT - 1; k >= 0; k--)
            if (hit_vec[k])
                hit_idx = 5'(k);
        hit_pat = pat_entry(hit_idx);
    end

    always_comb
    begin
        dq_ok = dq_open_reg ? !(fill_reg > 4'd1 && !is_boundary(win_reg[1]))
                            : !(have_prev_reg && !is_boundary(prev_reg));
        sq_ok = sq_open_reg ? !(fill_reg > 4'd1 && !is_boundary(win_reg[1]))
                            : !(have_prev_reg && !is_boundary(prev_reg));
        dec_skip    = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;
        dec_dq_flip = 1'b0;
        dec_sq_flip = 1'b0;
        priority if (skip_reg != 3'd0)
            dec_str = '{64'd0, 4'd0};
        else if (smart_mode && (hit_vec != '0))
        begin
            dec_str  = ent_text(hit_pat.ent);
            dec_skip = hit_pat.skip;
        end
        else if (smart_mode && head_byte == CH_DQ && dq_ok)
        begin
            dec_str     = quote_text(dq_open_reg, 1'b0);
            dec_dq_flip = 1'b1;
        end
        else if (smart_mode && head_byte == CH_SQ && sq_ok)
        begin
            dec_str     = quote_text(sq_open_reg, 1'b1);
            dec_sq_flip = 1'b1;
        end
        else
            dec_str = esc_text(head_byte);
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit_idx = 3'(rem_reg - 4'd1);

    always_comb
    begin
        state_next      = state_reg;
        win_next        = win_reg;
        fill_next       = fill_reg;
        prev_next       = prev_reg;
        have_prev_next  = have_prev_reg;
        skip_next       = skip_reg;
        sq_open_next    = sq_open_reg;
        dq_open_next    = dq_open_reg;
        flush_next      = flush_reg;
        rem_next        = rem_reg;
        buf_next        = buf_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        push_out        = 1'b0;
        push_word       = '{hold_byte_reg, 1'b0};
        pop             = 1'b0;

        unique case (state_reg)
            S_FETCH:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.cmd.op == OP_PARA)
                    begin
                        sq_open_next = 1'b0;
                        dq_open_next = 1'b0;
                    end
                    else
                    begin
                        win_next[fill_reg[2:0]] = head.cmd.data;
                        fill_next  = fill_reg + 4'd1;
                        flush_next = (head.cmd.op == OP_FLUSH);
                        if (head.cmd.op == OP_FLUSH || fill_reg == 4'(WIN_DEPTH - 1))
                            state_next = S_RENDER;
                    end
                end
            end
            S_RENDER:
            begin
                win_next       = win_reg >> 8;
                fill_next      = fill_reg - 4'd1;
                prev_next      = head_byte;
                have_prev_next = 1'b1;
                skip_next      = dec_skip;
                dq_open_next   = dq_open_reg ^ dec_dq_flip;
                sq_open_next   = sq_open_reg ^ dec_sq_flip;
                buf_next       = dec_str.text;
                rem_next       = dec_str.len;
                if (dec_str.len != 4'd0)
                    state_next = S_EMIT;
                else if (flush_reg && fill_reg > 4'd1)
                    state_next = S_RENDER;
                else
                    state_next = S_DONE;
            end
            S_EMIT:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    push_out        = hold_valid_reg;
                    hold_valid_next = 1'b1;
                    hold_byte_next  = buf_reg[{emit_idx, 3'b000} +: 8];
                    rem_next        = rem_reg - 4'd1;
                    if (rem_reg == 4'd1)
                        state_next = (flush_reg && fill_reg != 4'd0) ? S_RENDER : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!hold_valid_reg || out_free)
                begin
                    push_out        = hold_valid_reg;
                    push_word       = '{hold_byte_reg, 1'b1};
                    hold_valid_next = 1'b0;
                    if (flush_reg)
                    begin
                        prev_next      = 8'd0;
                        have_prev_next = 1'b0;
                        skip_next      = 3'd0;
                    end
                    state_next = S_FETCH;
                end
            end
            default:
                state_next = S_FETCH;
        endcase

        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (out_free)
        begin
            out_valid_next = push_out;
            if (push_out)
                out_word_next = push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FETCH;
            fill_reg       <= 4'd0;
            prev_reg       <= 8'd0;
            have_prev_reg  <= 1'b0;
            skip_reg       <= 3'd0;
            sq_open_reg    <= 1'b0;
            dq_open_reg    <= 1'b0;
            flush_reg      <= 1'b0;
            rem_reg        <= 4'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            prev_reg       <= prev_next;
            have_prev_reg  <= have_prev_next;
            skip_reg       <= skip_next;
            sq_open_reg    <= sq_open_next;
            dq_open_reg    <= dq_open_next;
            flush_reg      <= flush_next;
            rem_reg        <= rem_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        buf_reg       <= buf_next;
        hold_byte_reg <= hold_byte_next;
        out_word_reg  <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 4'(WIN_DEPTH))
        else $error("window overfilled");

    a_hold_empty_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !hold_valid_reg)
        else $error("held word left over at item boundary");

    a_emit_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (rem_reg != 4'd0))
        else $error("emit with nothing left");

endmodule
`default_nettype wire

### hdl/typographic_substitution_stream.sv
`default_nettype none
// ============================================================================
// typographic_substitution_stream
// Text bytes in, HTML bytes out, with optional typographic substitution.
// ============================================================================
//
//   channel   direction   payload     handshake
//   -------   ---------   ---------   ------------------------
//   in        input       tss_in_t    in_valid / in_stall
//   out       output      tss_out_t   out_valid / out_stall
//   cfg       input       smart_mode  cfg_we (no stall)
//
// steps: a word that renders nothing is only fetched in the back stage; a word
//   that renders is fetched, then each window byte is rendered and its entity
//   (0 to 8 bytes) emitted, then it finishes; single-byte emit sets the rate
// reset: rst_n clears the window fill, quote flags, queue and sets smart_mode
// stalls: the front register and queue keep taking words while the back stage
//   emits; out_stall holds the output register, the held byte and the emitter
//
module typographic_substitution_stream #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire tss_pkg::tss_in_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output tss_pkg::tss_out_t      out_word,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata
);
    import tss_pkg::*;

    // mode bit, sampled as each byte leaves the window head
    logic      smart_mode_reg;

    tss_link_t front_cmd;
    tss_link_t q_head;
    logic      q_full;
    logic      q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smart_mode_reg <= 1'b1;
        else if (cfg_we)
            smart_mode_reg <= cfg_wdata;
    end

    // classify incoming words
    tss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .cmd      (front_cmd),
        .q_full   (q_full)
    );

    // decouples intake from rendering
    tss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_cmd),
        .full  (q_full),
        .head  (q_head),
        .pop   (q_pop)
    );

    // window, matching and emission
    tss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .smart_mode (smart_mode_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule
`default_nettype wire
